[rtl/card_number_luhn_check_and_brand_core_defines.svh]
`ifndef CARD_NUMBER_LUHN_CHECK_AND_BRAND_CORE_DEFINES_SVH
`define CARD_NUMBER_LUHN_CHECK_AND_BRAND_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CNLCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnlcb assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define CNLCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnlcb assertion failed");

`endif

[rtl/cnlcb_pkg.sv]
package cnlcb_pkg;

  localparam int NUM_BITS   = 54;
  localparam int NUM_DIGITS = 17;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int BIT_CNT_W  = 6;
  localparam int DIG_IDX_W  = 5;

  localparam logic [2:0] VERDICT_INVALID = 3'd0;
  localparam logic [2:0] VERDICT_BRAND_A = 3'd1;
  localparam logic [2:0] VERDICT_BRAND_M = 3'd2;
  localparam logic [2:0] VERDICT_BRAND_V = 3'd3;
  localparam logic [2:0] VERDICT_OTHER   = 3'd4;

  typedef struct packed {
    logic clear;
    logic shift_bin;
    logic shift_dig;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic [DIG_IDX_W-1:0] count;
    logic                 pass;
    logic [3:0]           top;
    logic [3:0]           second;
  } scan_res_t;

endpackage

[rtl/cnlcb_cell.sv]
module cnlcb_cell (
  input  logic                clk,
  input  cnlcb_pkg::cell_ctl_t ctl,
  input  logic                bit_in,
  input  logic [3:0]          dig_in,
  output logic                bit_out,
  output logic [3:0]          dig_out
);

  logic [3:0] dig_r;
  logic [3:0] dig_nxt;
  logic [3:0] adj;

  always_comb begin
    adj = (dig_r >= 4'd5) ? dig_r + 4'd3 : dig_r;
    dig_nxt = dig_r;
    if (ctl.clear) begin
      dig_nxt = 4'd0;
    end else if (ctl.shift_bin) begin
      dig_nxt = {adj[2:0], bit_in};
    end else if (ctl.shift_dig) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

  assign bit_out = adj[3];
  assign dig_out = dig_r;

endmodule

[rtl/cnlcb_scan.sv]
module cnlcb_scan (
  input  logic                  clk,
  input  cnlcb_pkg::scan_ctl_t  ctl,
  input  logic [3:0]            dig,
  output cnlcb_pkg::scan_res_t  res
);

  logic [cnlcb_pkg::DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [cnlcb_pkg::DIG_IDX_W-1:0] cnt_r, cnt_nxt;
  logic [3:0] sum_r, sum_nxt;
  logic [3:0] prev_r, prev_nxt;
  logic [3:0] top_r, top_nxt;
  logic [3:0] sec_r, sec_nxt;
  logic [4:0] dbl;
  logic [3:0] addend;
  logic [4:0] acc;

  always_comb begin
    dbl    = {dig, 1'b0};
    addend = dig;
    if (idx_r[0]) begin
      addend = (dig >= 4'd5) ? 4'(dbl - 5'd9) : dbl[3:0];
    end
    acc = {1'b0, sum_r} + {1'b0, addend};
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    prev_nxt = prev_r;
    top_nxt  = top_r;
    sec_nxt  = sec_r;
    if (ctl.start) begin
      idx_nxt  = '0;
      cnt_nxt  = '0;
      sum_nxt  = 4'd0;
      prev_nxt = 4'd0;
      top_nxt  = 4'd0;
      sec_nxt  = 4'd0;
    end else if (ctl.step) begin
      idx_nxt  = idx_r + 1'b1;
      sum_nxt  = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
      prev_nxt = dig;
      if (dig != 4'd0) begin
        cnt_nxt = idx_r + 1'b1;
        top_nxt = dig;
        sec_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    sum_r  <= sum_nxt;
    prev_r <= prev_nxt;
    top_r  <= top_nxt;
    sec_r  <= sec_nxt;
  end

  always_comb begin
    res.count  = cnt_r;
    res.pass   = (sum_r == 4'd0);
    res.top    = top_r;
    res.second = sec_r;
  end

endmodule

[rtl/card_number_luhn_check_and_brand_core.sv]
// Flow: an accepted card number is shifted bit-serially into the 17-cell decimal chain
// (ST_CONV), its digits are scanned (ST_SCAN), and the result is registered in ST_DONE.
// A new card number is taken only in ST_IDLE, once the previous result has been registered;
// a stalled result holds the last step.
// Reset: synchronous, active-low rst_n; returns to idle with no result pending.
module card_number_luhn_check_and_brand_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cnlcb_pkg::IN_TDATA_W-1:0]    in_tdata,   // [53:0] card_number
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [cnlcb_pkg::OUT_TDATA_W-1:0]   out_tdata   // [2:0] verdict, [7:3] digit_count,
                                                          // [8] luhn_pass
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam int N = cnlcb_pkg::NUM_DIGITS;

  state_t state_r;
  logic [cnlcb_pkg::NUM_BITS-1:0]  num_r;
  logic [cnlcb_pkg::BIT_CNT_W-1:0] bcnt_r;
  logic [cnlcb_pkg::DIG_IDX_W-1:0] dcnt_r;
  logic                            out_tvalid_r;
  logic [cnlcb_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic in_xfer;
  logic out_free;
  cnlcb_pkg::cell_ctl_t cell_ctl;
  cnlcb_pkg::scan_ctl_t scan_ctl;
  cnlcb_pkg::scan_res_t scan_res;
  logic [N-1:0] carry;
  logic [3:0]   dig [N];
  logic [2:0]   verdict;
  logic         len_ok;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    cell_ctl.clear     = in_xfer;
    cell_ctl.shift_bin = (state_r == ST_CONV);
    cell_ctl.shift_dig = (state_r == ST_SCAN);
    scan_ctl.start     = in_xfer;
    scan_ctl.step      = (state_r == ST_SCAN);
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic       b_in;
    logic [3:0] d_in;
    if (i == 0) begin : g_lo
      assign b_in = num_r[cnlcb_pkg::NUM_BITS-1];
    end else begin : g_mid
      assign b_in = carry[i-1];
    end
    if (i == N-1) begin : g_hi
      assign d_in = 4'd0;
    end else begin : g_nhi
      assign d_in = dig[i+1];
    end
    cnlcb_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl),
      .bit_in  (b_in),
      .dig_in  (d_in),
      .bit_out (carry[i]),
      .dig_out (dig[i])
    );
  end

  cnlcb_scan u_scan (
    .clk (clk),
    .ctl (scan_ctl),
    .dig (dig[0]),
    .res (scan_res)
  );

  always_comb begin
    len_ok = (scan_res.count == 5'd13) || (scan_res.count == 5'd15) ||
             (scan_res.count == 5'd16);
    verdict = cnlcb_pkg::VERDICT_INVALID;
    if (len_ok && scan_res.pass) begin
      if ((scan_res.count == 5'd15) && (scan_res.top == 4'd3) &&
          ((scan_res.second == 4'd4) || (scan_res.second == 4'd7))) begin
        verdict = cnlcb_pkg::VERDICT_BRAND_A;
      end else if ((scan_res.count == 5'd16) && (scan_res.top == 4'd5) &&
                   (scan_res.second >= 4'd1) && (scan_res.second <= 4'd5)) begin
        verdict = cnlcb_pkg::VERDICT_BRAND_M;
      end else if (((scan_res.count == 5'd13) || (scan_res.count == 5'd16)) &&
                   (scan_res.top == 4'd4)) begin
        verdict = cnlcb_pkg::VERDICT_BRAND_V;
      end else begin
        verdict = cnlcb_pkg::VERDICT_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      bcnt_r       <= '0;
      dcnt_r       <= '0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != ST_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            num_r   <= in_tdata[cnlcb_pkg::NUM_BITS-1:0];
            bcnt_r  <= '0;
            state_r <= ST_CONV;
          end
        end
        ST_CONV: begin
          num_r  <= {num_r[cnlcb_pkg::NUM_BITS-2:0], 1'b0};
          bcnt_r <= bcnt_r + 1'b1;
          if (bcnt_r == cnlcb_pkg::BIT_CNT_W'(cnlcb_pkg::NUM_BITS - 1)) begin
            dcnt_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          dcnt_r <= dcnt_r + 1'b1;
          if (dcnt_r == cnlcb_pkg::DIG_IDX_W'(N - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {7'd0, scan_res.pass, scan_res.count, verdict};
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[rtl/cnlcb_checker.sv]
`include "card_number_luhn_check_and_brand_core_defines.svh"

module cnlcb_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [cnlcb_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic [2:0] verdict;
  logic [4:0] digits;
  logic       branded;

  assign verdict = out_tdata[2:0];
  assign digits  = out_tdata[7:3];
  assign branded = out_tvalid && (verdict != cnlcb_pkg::VERDICT_INVALID);

  `CNLCB_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `CNLCB_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `CNLCB_ASSERT_NOW(a_valid_needs_pass, branded, out_tdata[8])
  `CNLCB_ASSERT_NOW(a_valid_needs_len, branded, (digits == 5'd13) || (digits == 5'd15) || (digits == 5'd16))

endmodule

bind card_number_luhn_check_and_brand_core cnlcb_checker u_cnlcb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
